@@ rtl/mvcc_version_store_core_defines.svh @@
// Assertion macros shared by the version store RTL.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef MVCC_VERSION_STORE_CORE_DEFINES_SVH
`define MVCC_VERSION_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define MVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mvs_pkg.sv @@
// Shared sizes, codes and control types of the version store.
// Depends on nothing; imported by every module of the block except mvs_ram.
`timescale 1ns / 1ps

package mvs_pkg;

    // Store geometry
    localparam int KEYS     = 1024;
    localparam int VERSIONS = 8;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int KEY_FW  = 10;
    localparam int STAMP_W = 31;
    localparam int VALUE_W = 32;

    // Derived widths
    localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SLOT_W = (VERSIONS > 1) ? $clog2(VERSIONS) : 1;
    localparam int CNT_W  = $clog2(VERSIONS + 1);
    localparam int VER_D  = KEYS * VERSIONS;
    localparam int VER_AW = (VER_D > 1) ? $clog2(VER_D) : 1;

    // Packed stream widths
    localparam int S_DATA_BITS = KEY_FW + STAMP_W + VALUE_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = VALUE_W;
    localparam int USER_W      = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Control from the sequencer to the shared compare unit
    typedef struct packed {
        logic              clear;
        logic              step;
        logic [SLOT_W-1:0] slot;
    } scan_ctl_t;

    // Running result of the compare unit
    typedef struct packed {
        logic               hit;
        logic [STAMP_W-1:0] stamp;
        logic [SLOT_W-1:0]  slot;
    } scan_res_t;

endpackage

@@ rtl/mvs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mvs_scan_unit.sv @@
// Shared stamp compare unit: tracks the newest version not newer than the request.
// Depends on mvs_pkg.
`timescale 1ns / 1ps

module mvs_scan_unit
    import mvs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [STAMP_W-1:0] txn,
    output scan_res_t          res
);

    logic               hit_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               take;

    // Candidate is not newer than the request and beats the current best
    assign take = ctl.step && (stamp <= txn) && (!hit_reg || (stamp > best_reg));

    // Hit flag is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (take)
        begin
            hit_reg <= 1'b1;
        end
    end

    // Best stamp and its slot
    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            best_reg <= stamp;
            slot_reg <= ctl.slot;
        end
    end

    assign res.hit   = hit_reg;
    assign res.stamp = best_reg;
    assign res.slot  = slot_reg;

endmodule

@@ rtl/mvcc_version_store_core.sv @@
// Multiversion key store with timestamp-ordering checks. One request (read, check
// write or write) is taken at a time: the key's version count is read, then its
// stamps are scanned one per cycle through a single compare unit, the chosen version
// is read and the update is written back. The result and s_tready return together, so
// a new request is taken only after the last one's result is out; the stamp scan on the
// one stamp memory port makes the time per request grow with the key's version count.
// A result still waiting on m_tready holds the block in its last state, S_ACT. After
// reset a clearing pass resets every key's count and first version; s_tready stays
// low meanwhile.
// Depends on mvs_pkg, mvs_ram, mvs_scan_unit and mvcc_version_store_core_defines.svh.
`timescale 1ns / 1ps
`include "mvcc_version_store_core_defines.svh"

module mvcc_version_store_core
    import mvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // key, txn_stamp, write_value, zero pad
    input  logic [USER_W-1:0]   s_tuser,  // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // read_value
    output logic [USER_W-1:0]   m_tuser   // ok, list_full
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CNT,
        S_SCAN0,
        S_SCAN,
        S_TGT,
        S_ACT
    } state_t;

    state_t             state_reg;
    logic [KEY_AW-1:0]  clr_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [OP_W-1:0]    op_reg;
    logic [KEY_AW-1:0]  key_reg;
    logic [STAMP_W-1:0] txn_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               live_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic               out_full_reg;
    logic [VALUE_W-1:0] out_data_reg;

    // Unpacked request fields
    logic [OP_W-1:0]    in_op;
    logic [KEY_FW-1:0]  in_key;
    logic [STAMP_W-1:0] in_txn;
    logic [VALUE_W-1:0] in_val;
    logic               in_live;
    logic               accept;

    // Memory ports
    logic               cnt_we;
    logic [KEY_AW-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic               cnt_re;
    logic [CNT_W-1:0]   cnt_rdata;
    logic               stp_we;
    logic               stp_re;
    logic [VER_AW-1:0]  stp_raddr;
    logic [STAMP_W-1:0] stp_wdata;
    logic [STAMP_W-1:0] stp_rdata;
    logic               val_we;
    logic [VALUE_W-1:0] val_wdata;
    logic [VALUE_W-1:0] val_rdata;
    logic               rst_we;
    logic [STAMP_W-1:0] rst_wdata;
    logic [STAMP_W-1:0] rst_rdata;
    logic               tgt_re;
    logic [VER_AW-1:0]  ver_waddr;

    // Addressing
    logic [VER_AW-1:0]  base;
    logic [VER_AW-1:0]  clr_base;
    logic [VER_AW-1:0]  tgt_addr;
    logic [VER_AW-1:0]  app_addr;
    logic [CNT_W-1:0]   cnt_clamp;

    // Compare unit
    scan_ctl_t          scan_ctl;
    scan_res_t          scan_res;

    // Result of the current request
    logic               res_ok;
    logic               res_full;
    logic [VALUE_W-1:0] res_val;
    logic               leave_act;

    assign in_op   = s_tuser[OP_W-1:0];
    assign in_key  = s_tdata[KEY_FW-1:0];
    assign in_txn  = s_tdata[KEY_FW +: STAMP_W];
    assign in_val  = s_tdata[KEY_FW+STAMP_W +: VALUE_W];
    assign in_live = ({1'b0, in_key} < (KEY_FW+1)'(KEYS)) && (in_op != OP_UNUSED);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign base      = VER_AW'(key_reg * VERSIONS);
    assign clr_base  = VER_AW'(clr_reg * VERSIONS);
    assign tgt_addr  = base + VER_AW'(scan_res.slot);
    assign app_addr  = base + VER_AW'(cnt_reg);
    assign cnt_clamp = (cnt_rdata > CNT_W'(VERSIONS)) ? CNT_W'(VERSIONS) : cnt_rdata;
    assign leave_act = (state_reg == S_ACT) && (!out_valid_reg || m_tready);

    // Drive the compare unit during the stamp scan
    always_comb
    begin
        scan_ctl.clear = (state_reg == S_SCAN0);
        scan_ctl.step  = (state_reg == S_SCAN);
        scan_ctl.slot  = SLOT_W'(idx_reg - CNT_W'(1));
    end

    // Result and write-back of the current request, and the clearing writes after reset
    always_comb
    begin
        res_ok    = 1'b0;
        res_full  = 1'b0;
        res_val   = '0;
        val_we    = 1'b0;
        stp_we    = 1'b0;
        rst_we    = 1'b0;
        cnt_we    = 1'b0;
        ver_waddr = tgt_addr;
        val_wdata = val_reg;
        stp_wdata = txn_reg;
        rst_wdata = txn_reg;
        cnt_waddr = key_reg;
        cnt_wdata = cnt_reg + CNT_W'(1);
        if (state_reg == S_CLR)
        begin
            // Reset one key's count and first version
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = CNT_W'(1);
            val_we    = 1'b1;
            stp_we    = 1'b1;
            rst_we    = 1'b1;
            ver_waddr = clr_base;
            val_wdata = '0;
            stp_wdata = '0;
            rst_wdata = '0;
        end
        else if (state_reg == S_ACT && live_reg)
        begin
            unique case (op_reg)
                OP_READ:
                begin
                    if (scan_res.hit)
                    begin
                        res_ok  = 1'b1;
                        res_val = val_rdata;
                        rst_we  = leave_act && (rst_rdata < txn_reg);
                    end
                end
                OP_CHECK:
                begin
                    res_ok = !(scan_res.hit && (rst_rdata > txn_reg));
                end
                OP_WRITE:
                begin
                    if (scan_res.hit && (scan_res.stamp == txn_reg))
                    begin
                        res_ok = 1'b1;
                        val_we = leave_act;
                    end
                    else if (cnt_reg < CNT_W'(VERSIONS))
                    begin
                        res_ok    = 1'b1;
                        ver_waddr = app_addr;
                        val_we    = leave_act;
                        stp_we    = leave_act;
                        rst_we    = leave_act;
                        cnt_we    = leave_act;
                    end
                    else
                    begin
                        res_full = 1'b1;
                    end
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    // Read enables and stamp read address
    assign cnt_re    = (state_reg == S_CNT);
    assign tgt_re    = (state_reg == S_TGT);
    assign stp_re    = (state_reg == S_SCAN0) || ((state_reg == S_SCAN) && (idx_reg < cnt_reg));
    assign stp_raddr = (state_reg == S_SCAN0) ? base : (base + VER_AW'(idx_reg));

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (leave_act)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + KEY_AW'(1);
                    if (clr_reg == KEY_AW'(KEYS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CNT;
                    end
                end
                S_CNT:
                begin
                    state_reg <= S_SCAN0;
                end
                S_SCAN0:
                begin
                    cnt_reg   <= cnt_clamp;
                    idx_reg   <= CNT_W'(1);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_TGT;
                    end
                end
                S_TGT:
                begin
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    if (leave_act)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold request fields and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            key_reg  <= KEY_AW'(in_key);
            txn_reg  <= in_txn;
            val_reg  <= in_val;
            live_reg <= in_live;
        end
        if (leave_act)
        begin
            out_ok_reg   <= res_ok;
            out_full_reg <= res_full;
            out_data_reg <= res_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_full_reg, out_ok_reg};

    // Per-key version count
    mvs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (KEYS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (key_reg),
        .rdata (cnt_rdata)
    );

    // Version write stamps
    mvs_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (VER_D)
    ) u_stp_ram (
        .clk   (clk),
        .we    (stp_we),
        .waddr (ver_waddr),
        .wdata (stp_wdata),
        .re    (stp_re),
        .raddr (stp_raddr),
        .rdata (stp_rdata)
    );

    // Version values
    mvs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VER_D)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (ver_waddr),
        .wdata (val_wdata),
        .re    (tgt_re),
        .raddr (tgt_addr),
        .rdata (val_rdata)
    );

    // Version read stamps
    mvs_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (VER_D)
    ) u_rst_ram (
        .clk   (clk),
        .we    (rst_we),
        .waddr (ver_waddr),
        .wdata (rst_wdata),
        .re    (tgt_re),
        .raddr (tgt_addr),
        .rdata (rst_rdata)
    );

    // Shared stamp compare
    mvs_scan_unit u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .stamp (stp_rdata),
        .txn   (txn_reg),
        .res   (scan_res)
    );

    // Checks
    `MVS_ASSERT_NEXT(a_one_at_a_time, accept, !s_tready, "request accepted while busy")
    `MVS_ASSERT_IMP(a_full_not_ok, m_tvalid, !(m_tuser[0] && m_tuser[1]), "full write marked ok")
    `MVS_ASSERT_IMP(a_value_needs_ok, m_tvalid && (m_tdata != '0), m_tuser[0], "value without ok")
    `MVS_ASSERT_IMP(a_scan_in_list, state_reg == S_SCAN, idx_reg <= cnt_reg, "scan past count")

endmodule

@@ tb/mvs_result_checker.sv @@
// Scoreboard for the version store: watches both stream channels, predicts
// each result from its own copy of the version lists and compares in order.
// Depends on mvs_pkg for sizes, widths and operation codes.
`timescale 1ns / 1ps

module mvs_result_checker
    import mvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // key, txn_stamp, write_value, zero pad
    input  logic [USER_W-1:0]   s_tuser,  // opcode
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,  // read_value
    input  logic [USER_W-1:0]   m_tuser,  // ok, list_full
    output int                  fail_count,
    output int                  outstanding
);

    localparam int PEND_DEPTH = 16;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic               list_full;
    } access_result_t;

    // Shadow copy of every key's version list
    logic [VALUE_W-1:0] shadow_value  [KEYS][VERSIONS];
    logic [STAMP_W-1:0] shadow_stamp  [KEYS][VERSIONS];
    logic [STAMP_W-1:0] shadow_rstamp [KEYS][VERSIONS];
    int unsigned        shadow_count  [KEYS];

    // Ring of expected results, oldest at pend_head
    access_result_t pending_results [PEND_DEPTH];
    int unsigned    pend_head;
    int unsigned    pend_tail;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        pend_head   = 0;
        pend_tail   = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            shadow_count[k]     = 1;
            shadow_value[k][0]  = '0;
            shadow_stamp[k][0]  = '0;
            shadow_rstamp[k][0] = '0;
        end
    end

    // Apply one access to the shadow lists and return what the block must answer
    function automatic access_result_t apply_access(input logic [OP_W-1:0]    op,
                                                    input logic [KEY_FW-1:0]  key,
                                                    input logic [STAMP_W-1:0] txn,
                                                    input logic [VALUE_W-1:0] val);
        access_result_t     res;
        logic               hit;
        int unsigned        tgt;
        int unsigned        cnt;
        logic [STAMP_W-1:0] best;
        res  = '0;
        hit  = 1'b0;
        tgt  = 0;
        best = '0;
        if (key < KEYS && (op == OP_READ || op == OP_CHECK || op == OP_WRITE))
        begin
            cnt = shadow_count[key];
            // Find the newest version not newer than the transaction
            for (int i = 0; i < cnt; i++)
            begin
                if (shadow_stamp[key][i] <= txn && (!hit || shadow_stamp[key][i] > best))
                begin
                    hit  = 1'b1;
                    best = shadow_stamp[key][i];
                    tgt  = i;
                end
            end
            case (op)
                OP_READ:
                begin
                    if (hit)
                    begin
                        res.ok         = 1'b1;
                        res.read_value = shadow_value[key][tgt];
                        if (shadow_rstamp[key][tgt] < txn)
                            shadow_rstamp[key][tgt] = txn;
                    end
                end
                OP_CHECK:
                begin
                    res.ok = !(hit && shadow_rstamp[key][tgt] > txn);
                end
                default:
                begin
                    if (hit && shadow_stamp[key][tgt] == txn)
                    begin
                        shadow_value[key][tgt] = val;
                        res.ok = 1'b1;
                    end
                    else if (cnt < VERSIONS)
                    begin
                        shadow_value[key][cnt]  = val;
                        shadow_stamp[key][cnt]  = txn;
                        shadow_rstamp[key][cnt] = txn;
                        shadow_count[key]       = cnt + 1;
                        res.ok = 1'b1;
                    end
                    else
                    begin
                        res.list_full = 1'b1;
                    end
                end
            endcase
        end
        return res;
    endfunction

    // Compare finished results, then record newly accepted requests
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pend_head == pend_tail)
                begin
                    $display("%0t: unexpected result ok=%0b value=%h full=%0b",
                             $time, m_tuser[0], m_tdata, m_tuser[1]);
                    fail_count++;
                end
                else
                begin
                    want = pending_results[pend_head % PEND_DEPTH];
                    pend_head++;
                    if (m_tuser[0] !== want.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0b, actual %0b",
                                 $time, want.ok, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.read_value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.list_full)
                    begin
                        $display("%0t: list_full mismatch, expected %0b, actual %0b",
                                 $time, want.list_full, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (pend_tail - pend_head >= PEND_DEPTH)
                begin
                    $display("%0t: too many requests in flight, expected at most %0d, actual %0d",
                             $time, PEND_DEPTH, pend_tail - pend_head + 1);
                    fail_count++;
                end
                else
                begin
                    pending_results[pend_tail % PEND_DEPTH] = apply_access(
                        s_tuser[OP_W-1:0],
                        s_tdata[KEY_FW-1:0],
                        s_tdata[KEY_FW +: STAMP_W],
                        s_tdata[KEY_FW+STAMP_W +: VALUE_W]);
                    pend_tail++;
                end
            end
            outstanding = int'(pend_tail - pend_head);
        end
    end

endmodule

@@ tb/tb_mvcc_version_store_core.sv @@
// Top of the version store testbench: clock, reset, request stimulus with
// idle and stall phases, and the verdict; checking sits in mvs_result_checker.
// Depends on mvs_pkg, mvcc_version_store_core and mvs_result_checker.
`timescale 1ns / 1ps

module tb_mvcc_version_store_core;
    import mvs_pkg::*;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam int RANDOM_PER_PHASE = 262;
    localparam int HOT_KEYS = 6;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // key, txn_stamp, write_value, zero pad
    logic [USER_W-1:0]   s_tuser  = '0;  // opcode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // read_value
    logic [USER_W-1:0]   m_tuser;        // ok, list_full

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic [KEY_FW-1:0] hot_key [HOT_KEYS];

    mvcc_version_store_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mvs_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result channel at the current rate
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input logic [OP_W-1:0]    op,
                                input logic [KEY_FW-1:0]  key,
                                input logic [STAMP_W-1:0] txn,
                                input logic [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_DATA_W'({val, txn, key});
        s_tuser  = USER_W'(op);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Random accesses, mostly on a few hot keys so lists fill and stamps collide
    task automatic run_phase(input int idle_pct, input int stall_pct);
        logic [OP_W-1:0]    op;
        logic [KEY_FW-1:0]  key;
        logic [STAMP_W-1:0] txn;
        logic [VALUE_W-1:0] val;
        int                 pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int h = 0; h < HOT_KEYS; h++)
            hot_key[h] = KEY_FW'($urandom);
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            pick = $urandom_range(0, 99);
            op = (pick < 35) ? OP_READ : (pick < 60) ? OP_CHECK : OP_WRITE;
            if ($urandom_range(0, 99) < 75)
                key = hot_key[$urandom_range(0, HOT_KEYS - 1)];
            else
                key = KEY_FW'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                txn = STAMP_W'($urandom_range(0, 63));
            else if (pick < 75)
                txn = STAMP_MAX - STAMP_W'($urandom_range(0, 63));
            else
                txn = STAMP_W'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                val = 32'h7FFF_FFFF;
            else if (pick == 1)
                val = 32'h8000_0000;
            else
                val = $urandom;
            send_request(op, key, txn, val);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of key, stamp and value on fresh keys
        send_request(OP_READ,  10'd0,    31'd0,     32'd0);
        send_request(OP_WRITE, 10'd0,    31'd0,     32'h7FFF_FFFF);   // equal stamp
        send_request(OP_READ,  10'd0,    STAMP_MAX, 32'hFFFF_FFFF);
        send_request(OP_CHECK, 10'd0,    31'd5,     32'd0);           // read later
        send_request(OP_WRITE, 10'd1023, STAMP_MAX, 32'h8000_0000);   // append
        send_request(OP_READ,  10'd1023, STAMP_MAX - 31'd1, 32'd0);
        send_request(OP_CHECK, 10'd1023, STAMP_MAX, 32'd0);
        // Fill one key's list, then overflow it
        for (int i = 1; i < VERSIONS; i++)
            send_request(OP_WRITE, 10'd5, STAMP_W'(i * 10), 32'(i) - 32'd1);
        send_request(OP_WRITE, 10'd5, 31'd80, 32'h1234_5678);         // full
        send_request(OP_WRITE, 10'd5, 31'd30, 32'hFFFF_FFFF);         // overwrite while full
        send_request(OP_WRITE, 10'd5, 31'd15, 32'h5555_5555);         // older, full
        send_request(OP_UNUSED, 10'd5, 31'd30, 32'hAAAA_AAAA);
        send_request(OP_READ,  10'd5, 31'd35, 32'd0);
        send_request(OP_CHECK, 10'd5, 31'd25, 32'd0);                 // passes
        send_request(OP_CHECK, 10'd5, 31'd32, 32'd0);                 // read by later txn

        // Random phases with different idle and stall patterns
        run_phase(0, 0);
        run_phase(84, 0);
        // Hold the sender until every result is back
        while (outstanding != 0)
            @(negedge clk);
        run_phase(0, 84);
        run_phase(23, 23);

        // Drain and let the block settle
        send_idle_pct  = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mvs_pkg.sv
rtl/mvs_ram.sv
rtl/mvs_scan_unit.sv
rtl/mvcc_version_store_core.sv
tb/mvs_result_checker.sv
tb/tb_mvcc_version_store_core.sv
